// File: hw/rtl/cst_pkg.sv
// Package for the client session table: sizes, request codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package cst_pkg;

  // Table size and derived widths
  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CNT_W     = $clog2(MAX_PEERS + 1);

  // Fixed field widths of the request and response
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int AGE_W     = 16;
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [AGE_W-1:0] THRESHOLD_RESET = AGE_W'(1000);
  localparam logic [AGE_W-1:0] AGE_MAX         = '1;

  // Register index of the idle threshold
  localparam logic REG_IDLE_THRESHOLD = 1'b0;

  // Request type codes
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_req;   // capture request, restart scan
    logic inc_k;      // advance scan slot
    logic wr_hit;     // clear age of matched slot
    logic wr_age;     // write aged value back to scan slot
    logic wr_move;    // move last entry into scan slot, drop one entry
    logic wr_ins;     // append new peer
    logic set_full;   // flag a failed insert
    logic load_rsp;   // load response register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic in_range;   // scan slot below entry count
    logic match;      // scan entry equals request peer
    logic expire;     // aged scan entry reaches threshold
    logic full;       // no free slot
  } dp_status_t;

endpackage

// File: hw/rtl/cst_if.sv
// Valid/ready channel interfaces for requests and responses of the
// client session table. Depends on cst_pkg.
interface cst_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cst_pkg::ADDR_W-1:0]    src_addr;
  logic [cst_pkg::PORT_W-1:0]    src_port;
  logic [cst_pkg::AGE_W-1:0]     elapsed_ms;

  modport source (output valid, req_type, src_addr, src_port, elapsed_ms, input ready);
  modport sink   (input valid, req_type, src_addr, src_port, elapsed_ms, output ready);
endinterface

interface cst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cst_pkg::OUT_IDX_W-1:0] client_index;
  logic                          is_new;
  logic                          table_full;
  logic [cst_pkg::OUT_CNT_W-1:0] removed_count;
  logic [cst_pkg::OUT_CNT_W-1:0] live_count;

  modport source (output valid, client_index, is_new, table_full, removed_count, live_count,
                  input ready);
  modport sink   (input valid, client_index, is_new, table_full, removed_count, live_count,
                  output ready);
endinterface

// File: hw/rtl/cst_dp.sv
// Datapath of the client session table: peer memory, scan slot, entry
// count, threshold register and response register. Depends on cst_pkg.
module cst_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cst_pkg::dp_cmd_t              cmd,
  output cst_pkg::dp_status_t           status,
  input  logic                          in_req_type,
  input  logic [cst_pkg::ADDR_W-1:0]    in_src_addr,
  input  logic [cst_pkg::PORT_W-1:0]    in_src_port,
  input  logic [cst_pkg::AGE_W-1:0]     in_elapsed_ms,
  input  logic                          thr_we,
  input  logic [cst_pkg::AGE_W-1:0]     thr_wdata,
  output logic [cst_pkg::AGE_W-1:0]     threshold,
  output logic [cst_pkg::OUT_IDX_W-1:0] client_index,
  output logic                          is_new,
  output logic                          table_full,
  output logic [cst_pkg::OUT_CNT_W-1:0] removed_count,
  output logic [cst_pkg::OUT_CNT_W-1:0] live_count
);

  cst_pkg::entry_t                  mem [cst_pkg::MAX_PEERS];
  cst_pkg::entry_t                  rd_k;
  cst_pkg::entry_t                  rd_last;
  cst_pkg::entry_t                  wr_data;
  logic [cst_pkg::IDX_W-1:0]        wr_idx;
  logic                             wr_en;

  logic                             req_tick;
  logic [cst_pkg::ADDR_W-1:0]       req_addr;
  logic [cst_pkg::PORT_W-1:0]       req_port;
  logic [cst_pkg::AGE_W-1:0]        req_ms;

  logic [cst_pkg::CNT_W-1:0]        k;
  logic [cst_pkg::CNT_W-1:0]        count;
  logic [cst_pkg::CNT_W-1:0]        last;
  logic [cst_pkg::CNT_W-1:0]        gone;
  logic [cst_pkg::CNT_W-1:0]        res_idx;
  logic                             res_new;
  logic                             res_full;

  logic [cst_pkg::AGE_W:0]          age_sum;
  logic [cst_pkg::AGE_W-1:0]        aged;

  // Age the scan entry, saturating at the top of the range
  assign age_sum = {1'b0, rd_k.age} + {1'b0, req_ms};
  assign aged    = age_sum[cst_pkg::AGE_W] ? cst_pkg::AGE_MAX : age_sum[cst_pkg::AGE_W-1:0];
  assign last    = count - cst_pkg::CNT_W'(1);

  // Status toward the controller
  always_comb begin
    status.is_tick  = req_tick;
    status.in_range = (k < count);
    status.match    = (rd_k.addr == req_addr) && (rd_k.port == req_port);
    status.expire   = (aged >= threshold);
    status.full     = (count == cst_pkg::CNT_W'(cst_pkg::MAX_PEERS));
  end

  // Select the single memory write of this cycle
  always_comb begin
    wr_en   = cmd.wr_hit | cmd.wr_age | cmd.wr_move | cmd.wr_ins;
    wr_idx  = k[cst_pkg::IDX_W-1:0];
    wr_data = rd_k;
    if (cmd.wr_ins) begin
      wr_idx  = count[cst_pkg::IDX_W-1:0];
      wr_data = '{addr: req_addr, port: req_port, age: '0};
    end else if (cmd.wr_move) begin
      // When the scan slot is the last one the copy lands on a dropped slot
      wr_data = rd_last;
    end else if (cmd.wr_age) begin
      wr_data.age = aged;
    end else if (cmd.wr_hit) begin
      wr_data.age = '0;
    end
  end

  // Peer memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_k    <= mem[k[cst_pkg::IDX_W-1:0]];
    rd_last <= mem[last[cst_pkg::IDX_W-1:0]];
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_tick <= (in_req_type == cst_pkg::REQ_TICK);
      req_addr <= in_src_addr;
      req_port <= in_src_port;
      req_ms   <= in_elapsed_ms;
    end
  end

  // Scan slot, entry count, removal count and per-request result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      count    <= '0;
      gone     <= '0;
      res_idx  <= '0;
      res_new  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        k        <= '0;
        gone     <= '0;
        res_idx  <= '0;
        res_new  <= 1'b0;
        res_full <= 1'b0;
      end
      if (cmd.inc_k) begin
        k <= k + cst_pkg::CNT_W'(1);
      end
      if (cmd.wr_hit) begin
        res_idx <= k;
      end
      if (cmd.wr_ins) begin
        res_idx <= count;
        res_new <= 1'b1;
        count   <= count + cst_pkg::CNT_W'(1);
      end
      if (cmd.wr_move) begin
        count <= last;
        gone  <= gone + cst_pkg::CNT_W'(1);
      end
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
    end
  end

  // Idle threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= cst_pkg::THRESHOLD_RESET;
    end else if (thr_we) begin
      threshold <= thr_wdata;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      client_index  <= cst_pkg::OUT_IDX_W'(res_idx);
      is_new        <= res_new;
      table_full    <= res_full;
      removed_count <= cst_pkg::OUT_CNT_W'(gone);
      live_count    <= cst_pkg::OUT_CNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cst_pkg::CNT_W'(cst_pkg::MAX_PEERS))
    else $error("entry count above table size");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_move |-> (count != '0) && (k < count))
    else $error("removal from an empty table");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |=> count == $past(count) + cst_pkg::CNT_W'(1))
    else $error("insert did not grow the table");
`endif

endmodule

// File: hw/rtl/cst_ctrl.sv
// Controller of the client session table: sequences the slot scan for
// packet and tick requests and owns the response valid. Depends on cst_pkg.
module cst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cst_pkg::dp_status_t status,
  output cst_pkg::dp_cmd_t    cmd
);

  cst_pkg::state_t state;
  cst_pkg::state_t state_next;
  logic            out_free;
  logic            accept;

  assign in_ready = (state == cst_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cst_pkg::S_IDLE: begin
        if (accept) state_next = cst_pkg::S_READ;
      end
      cst_pkg::S_READ: begin
        state_next = status.in_range ? cst_pkg::S_CHECK : cst_pkg::S_DONE;
      end
      cst_pkg::S_CHECK: begin
        if (!status.is_tick && status.match) begin
          state_next = cst_pkg::S_DONE;
        end else begin
          state_next = cst_pkg::S_READ;
        end
      end
      cst_pkg::S_DONE: begin
        if (out_free) state_next = cst_pkg::S_IDLE;
      end
      default: state_next = cst_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      cst_pkg::S_IDLE: begin
        cmd.load_req = accept;
      end
      cst_pkg::S_READ: begin
        // Scan ran off the end: append the peer or flag a full table
        if (!status.in_range && !status.is_tick) begin
          cmd.wr_ins   = !status.full;
          cmd.set_full = status.full;
        end
      end
      cst_pkg::S_CHECK: begin
        if (status.is_tick) begin
          // Expired: pull the last entry in and check this slot again
          cmd.wr_move = status.expire;
          cmd.wr_age  = !status.expire;
          cmd.inc_k   = !status.expire;
        end else begin
          cmd.wr_hit = status.match;
          cmd.inc_k  = !status.match;
        end
      end
      cst_pkg::S_DONE: begin
        cmd.load_rsp = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // State and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cst_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_rsp) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == cst_pkg::S_READ)
    else $error("accepted request did not start a scan");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_hit, cmd.wr_age, cmd.wr_move, cmd.wr_ins}))
    else $error("more than one table write in a cycle");

  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == cst_pkg::S_DONE) && out_free |=> out_valid && (state == cst_pkg::S_IDLE))
    else $error("finished request did not post a response");

  a_no_full_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |-> !status.full)
    else $error("insert into a full table");
`endif

endmodule

// File: hw/rtl/client_session_table_with_idle_aging.sv
// Top level of the client session table: request/response channels, APB
// configuration port, controller and datapath. Depends on cst_pkg, cst_if,
// cst_ctrl and cst_dp.
//
// Keeps up to MAX_PEERS (16) live peers, each an IPv4 address, UDP port and
// idle age. A packet request scans the table in slot order and returns the
// matching slot with its age cleared, or appends the peer and flags it new,
// or flags table_full. A tick request adds elapsed_ms to every age
// (saturating at 65535) and removes entries at or above idle_threshold_ms
// (APB address 0) by moving the last entry into the freed slot, which is then
// checked again. One request is in work at a time; each examined slot passes
// through a registered memory read, then compare and write back. A removal
// revisits its slot but shrinks the table by one. If the previous response
// is still waiting, the request holds in S_DONE until that response is
// taken. A finished response waits in an output register while the next
// request is accepted.
module client_session_table_with_idle_aging (
  input  logic                        clk,
  input  logic                        rst,
  cst_req_if.sink                     req,
  cst_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cst_pkg::PADDR_W-1:0] paddr,
  input  logic [cst_pkg::PDATA_W-1:0] pwdata,
  output logic [cst_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  cst_pkg::dp_cmd_t          cmd;
  cst_pkg::dp_status_t       status;
  logic                      thr_we;
  logic [cst_pkg::AGE_W-1:0] threshold;
  logic                      reg_sel;

  // Decode the configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[cst_pkg::PADDR_W-1] == cst_pkg::REG_IDLE_THRESHOLD);
  assign thr_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? cst_pkg::PDATA_W'(threshold) : '0;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cst_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_req_type   (req.req_type),
    .in_src_addr   (req.src_addr),
    .in_src_port   (req.src_port),
    .in_elapsed_ms (req.elapsed_ms),
    .thr_we        (thr_we),
    .thr_wdata     (pwdata[cst_pkg::AGE_W-1:0]),
    .threshold     (threshold),
    .client_index  (rsp.client_index),
    .is_new        (rsp.is_new),
    .table_full    (rsp.table_full),
    .removed_count (rsp.removed_count),
    .live_count    (rsp.live_count)
  );

endmodule
